// ----- sv/mel_filterbank_log_dct_defines.svh -----
// Assertion helpers used by the checker of this block.
`ifndef MEL_FILTERBANK_LOG_DCT_DEFINES_SVH
`define MEL_FILTERBANK_LOG_DCT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define MFLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define MFLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mfld_pkg.sv -----
package mfld_pkg;

    localparam int MAX_BINS_DEF     = 1024;
    localparam int MAX_FILTERS_DEF  = 64;
    localparam int WEIGHT_DEPTH_DEF = 4096;

    localparam int DCT_DIM  = 64;
    localparam int INDEX_W  = 12;
    localparam int BIN_W    = 11;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 6;

    // Input item kinds, carried on tuser.
    localparam logic [1:0] KIND_WEIGHT    = 2'd0;
    localparam logic [1:0] KIND_FILTER    = 2'd1;
    localparam logic [1:0] KIND_DCT       = 2'd2;
    localparam logic [1:0] KIND_MAGNITUDE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_C0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FB_ONLY   = 3'd4;

    // Sum of magnitude times weight fits in 58 bits; top bit index.
    localparam int SUM_TOP = 57;

    localparam logic [17:0]        DB_PER_LOG2_Q16 = 18'd197283;
    localparam logic [23:0]        DB_OFFSET_Q8    = 24'd10240;
    localparam logic signed [23:0] DB_FLOOR_Q8     = -24'sd61440;
    localparam logic signed [63:0] FEAT_MAX        = 64'sd8388607;
    localparam logic signed [63:0] FEAT_MIN        = -64'sd8388608;

endpackage

// ----- sv/mel_filterbank_log_dct.sv -----
// Channel   Direction  Handshake                      Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready tdata, tuser=kind, tlast=frame_end
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready tdata, tlast=last
// cfg       in         i_cfg_valid/o_cfg_ready         i_cfg_index, i_cfg_data
//
// Filter, DCT and magnitude items are taken in S_IDLE; a weight goes on to S_WMOD, which
// subtracts WEIGHT_DEPTH from its address until it is in range and then writes it.
// A frame end runs one shared multiplier: per filter a descriptor read, address wrap, a
// MAC per bin, normalize shifts and a log multiply; per cepstral row a MAC per band
// filter (fb_only: log values go out as is); output stalls hold it. Input not ready then.
// Reset is synchronous and active low; stores hold no reset value and need no clearing.
module mel_filterbank_log_dct
    import mfld_pkg::*;
#(
    parameter int MAX_BINS     = MAX_BINS_DEF,
    parameter int MAX_FILTERS  = MAX_FILTERS_DEF,
    parameter int WEIGHT_DEPTH = WEIGHT_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // index[11:0], row[17:12], bin_begin[28:18], bin_end[39:29],
    // weight_base[51:40], value[83:52], zeros[87:84]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]             i_s_axis_tuser,
    input  logic                   i_s_axis_tlast,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // feature_index[5:0], feature[29:6], zeros[31:30]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SAW = $clog2(MAX_BINS);
    localparam int CW  = $clog2(MAX_BINS + 1);
    localparam int BW  = (CW > BIN_W) ? CW : BIN_W;
    localparam int WAW = $clog2(WEIGHT_DEPTH);
    localparam int WRW = ((WAW > INDEX_W) ? WAW : INDEX_W) + 1;
    localparam int FAW = $clog2(MAX_FILTERS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_WMOD     = 4'd1;
    localparam logic [3:0] S_F_START  = 4'd2;
    localparam logic [3:0] S_F_DESC   = 4'd3;
    localparam logic [3:0] S_F_WRAP   = 4'd4;
    localparam logic [3:0] S_F_RD     = 4'd5;
    localparam logic [3:0] S_F_MAC    = 4'd6;
    localparam logic [3:0] S_L_NORM   = 4'd7;
    localparam logic [3:0] S_L_MUL    = 4'd8;
    localparam logic [3:0] S_L_WR     = 4'd9;
    localparam logic [3:0] S_O_FB_RD  = 4'd10;
    localparam logic [3:0] S_O_FB_OUT = 4'd11;
    localparam logic [3:0] S_C_START  = 4'd12;
    localparam logic [3:0] S_C_RD     = 4'd13;
    localparam logic [3:0] S_C_MAC    = 4'd14;
    localparam logic [3:0] S_C_OUT    = 4'd15;

    // Stores
    logic [15:0]           mem_w     [WEIGHT_DEPTH];
    logic [BIN_W-1:0]      mem_first [MAX_FILTERS];
    logic [BIN_W-1:0]      mem_stop  [MAX_FILTERS];
    logic [INDEX_W-1:0]    mem_base  [MAX_FILTERS];
    logic [31:0]           mem_dct   [DCT_DIM*DCT_DIM];
    logic [30:0]           mem_spec  [MAX_BINS];
    logic [23:0]           mem_log   [DCT_DIM];

    logic [15:0]           r_w_q;
    logic [BIN_W-1:0]      r_first_q, r_stop_q;
    logic [INDEX_W-1:0]    r_base_q;
    logic [31:0]           r_coef_q;
    logic [30:0]           r_spec_q;
    logic [23:0]           r_log_q;

    // Configuration
    logic [5:0] r_band_low, r_band_high, r_num_cep;
    logic       r_keep_c0, r_fb_only;

    // Control and datapath registers
    logic [3:0]     r_state, n_state;
    logic [CW-1:0]  r_bin_cnt, n_bin_cnt;
    logic [6:0]     r_f, n_f, r_nband, n_nband, r_k, n_k, r_cnt, n_cnt;
    logic           r_fb, n_fb, r_start, n_start;
    logic [5:0]     r_row, n_row, r_p, n_p;
    logic [BW-1:0]  r_bin, n_bin, r_stop, n_stop;
    logic [WRW-1:0] r_waddr, n_waddr;
    logic [15:0]    r_wdata, n_wdata;
    logic [63:0]    r_acc, n_acc;
    logic           r_zero, n_zero;
    logic           r_out_valid, n_out_valid, r_out_last, n_out_last;
    logic [5:0]     r_out_idx, n_out_idx;
    logic [23:0]    r_out_feat, n_out_feat;

    logic                w_in_acc, w_slot;
    logic [1:0]          w_kind;
    logic [INDEX_W-1:0]  w_index, w_base;
    logic [5:0]          w_row;
    logic [BIN_W-1:0]    w_bin_begin, w_bin_end;
    logic [31:0]         w_value;
    logic [6:0]          w_nband, w_fi, w_pm16;
    logic [BW-1:0]       w_stop_clip;
    logic [5:0]          w_log_ra;
    logic [22:0]         w_l;
    logic signed [32:0]  w_ma;
    logic signed [24:0]  w_mb;
    logic signed [57:0]  w_prod;
    logic [63:0]         w_prod_ext;
    logic signed [63:0]  w_db_sh, w_v;
    logic [23:0]         w_db, w_sat;

    assign w_kind      = i_s_axis_tuser;
    assign w_index     = i_s_axis_tdata[11:0];
    assign w_row       = i_s_axis_tdata[17:12];
    assign w_bin_begin = i_s_axis_tdata[28:18];
    assign w_bin_end   = i_s_axis_tdata[39:29];
    assign w_base      = i_s_axis_tdata[51:40];
    assign w_value     = i_s_axis_tdata[83:52];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign w_slot          = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_feat, r_out_idx};
    assign o_m_axis_tlast  = r_out_last;

    assign w_nband = (r_band_low <= r_band_high) ?
                     ({1'b0, r_band_high - r_band_low} + 7'd1) : 7'd0;
    assign w_fi    = {1'b0, r_band_low} + r_f;
    assign w_stop_clip = (BW'(r_stop_q) > BW'(MAX_BINS)) ? BW'(MAX_BINS) : BW'(r_stop_q);
    assign w_log_ra = (r_state == S_O_FB_RD || r_state == S_O_FB_OUT) ? r_k[5:0] : r_f[5:0];

    // Mitchell log2: integer part from the leading-one position, fraction from the
    // bits right below it.
    assign w_pm16 = {1'b0, r_p} - 7'd16;
    assign w_l    = {w_pm16, r_acc[SUM_TOP-1 -: 16]};

    // The one shared multiplier.
    always_comb begin
        unique case (r_state)
            S_L_MUL: begin
                w_ma = {{10{w_l[22]}}, w_l};
                w_mb = {7'd0, DB_PER_LOG2_Q16};
            end
            S_C_MAC: begin
                w_ma = {r_coef_q[31], r_coef_q};
                w_mb = {r_log_q[23], r_log_q};
            end
            default: begin
                w_ma = {2'b00, r_spec_q};
                w_mb = {9'd0, r_w_q};
            end
        endcase
    end
    assign w_prod     = w_ma * w_mb;
    assign w_prod_ext = {{6{w_prod[57]}}, w_prod};

    assign w_db_sh = $signed(r_acc + 64'h0000_0000_0080_0000) >>> 24;
    assign w_db    = w_db_sh[23:0] - DB_OFFSET_Q8;

    assign w_v = $signed(r_acc + 64'h0000_0000_2000_0000) >>> 30;
    always_comb begin
        priority if (w_v > FEAT_MAX) w_sat = FEAT_MAX[23:0];
        else if (w_v < FEAT_MIN)     w_sat = FEAT_MIN[23:0];
        else                         w_sat = w_v[23:0];
    end

    // Sequencer
    always_comb begin
        n_state = r_state;   n_bin_cnt = r_bin_cnt; n_f = r_f;       n_nband = r_nband;
        n_k = r_k;           n_cnt = r_cnt;         n_fb = r_fb;     n_start = r_start;
        n_row = r_row;       n_p = r_p;             n_bin = r_bin;   n_stop = r_stop;
        n_waddr = r_waddr;   n_wdata = r_wdata;     n_acc = r_acc;   n_zero = r_zero;
        n_out_idx = r_out_idx; n_out_feat = r_out_feat; n_out_last = r_out_last;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (w_kind)
                        KIND_WEIGHT: begin
                            n_waddr = WRW'(w_index);
                            n_wdata = w_value[15:0];
                            n_state = S_WMOD;
                        end
                        KIND_FILTER, KIND_DCT: begin
                            n_state = S_IDLE;
                        end
                        KIND_MAGNITUDE: begin
                            if (r_bin_cnt < CW'(MAX_BINS)) n_bin_cnt = r_bin_cnt + CW'(1);
                            if (i_s_axis_tlast) begin
                                n_bin_cnt = '0;
                                n_f       = '0;
                                n_nband   = w_nband;
                                n_fb      = r_fb_only;
                                n_start   = !r_keep_c0;
                                n_cnt     = r_fb_only ? w_nband :
                                            ({1'b0, r_num_cep} + {6'd0, r_keep_c0});
                                n_state   = S_F_START;
                            end
                        end
                    endcase
                end
            end
            S_WMOD: begin
                if (r_waddr >= WRW'(WEIGHT_DEPTH)) n_waddr = r_waddr - WRW'(WEIGHT_DEPTH);
                else n_state = S_IDLE;
            end
            S_F_START: begin
                n_acc = '0;
                if (r_f == r_nband) begin
                    n_k     = '0;
                    n_state = r_fb ? S_O_FB_RD : S_C_START;
                end else if ({1'b0, w_fi} >= 8'(MAX_FILTERS)) begin
                    n_p     = 6'(SUM_TOP);
                    n_state = S_L_NORM;
                end else begin
                    n_state = S_F_DESC;
                end
            end
            S_F_DESC: begin
                n_bin   = BW'(r_first_q);
                n_stop  = w_stop_clip;
                n_waddr = WRW'(r_base_q);
                n_state = S_F_WRAP;
            end
            S_F_WRAP: begin
                if (r_waddr >= WRW'(WEIGHT_DEPTH)) n_waddr = r_waddr - WRW'(WEIGHT_DEPTH);
                else n_state = S_F_RD;
            end
            S_F_RD: begin
                if (r_bin >= r_stop) begin
                    n_p     = 6'(SUM_TOP);
                    n_state = S_L_NORM;
                end else begin
                    n_bin   = r_bin + BW'(1);
                    n_waddr = (r_waddr == WRW'(WEIGHT_DEPTH - 1)) ? '0 : r_waddr + WRW'(1);
                    n_state = S_F_MAC;
                end
            end
            S_F_MAC: begin
                n_acc   = r_acc + w_prod_ext;
                n_state = S_F_RD;
            end
            S_L_NORM: begin
                priority if (r_acc[SUM_TOP:0] == '0) begin
                    n_zero  = 1'b1;
                    n_state = S_L_WR;
                end else if (r_acc[SUM_TOP]) begin
                    n_zero  = 1'b0;
                    n_state = S_L_MUL;
                end else begin
                    n_acc = r_acc << 1;
                    n_p   = r_p - 6'd1;
                end
            end
            S_L_MUL: begin
                n_acc   = w_prod_ext;
                n_state = S_L_WR;
            end
            S_L_WR: begin
                n_f     = r_f + 7'd1;
                n_state = S_F_START;
            end
            S_O_FB_RD: begin
                n_state = (r_k == r_cnt) ? S_IDLE : S_O_FB_OUT;
            end
            S_O_FB_OUT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_k[5:0];
                    n_out_feat  = r_log_q;
                    n_out_last  = (r_k + 7'd1 == r_cnt);
                    n_k         = r_k + 7'd1;
                    n_state     = S_O_FB_RD;
                end
            end
            S_C_START: begin
                if (r_k == r_cnt) begin
                    n_state = S_IDLE;
                end else begin
                    n_acc   = '0;
                    n_f     = '0;
                    n_row   = r_k[5:0] + {5'd0, r_start};
                    n_state = S_C_RD;
                end
            end
            S_C_RD: begin
                if (r_f == r_nband) begin
                    n_state = S_C_OUT;
                end else begin
                    n_f     = r_f + 7'd1;
                    n_state = S_C_MAC;
                end
            end
            S_C_MAC: begin
                n_acc   = r_acc + w_prod_ext;
                n_state = S_C_RD;
            end
            S_C_OUT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_k[5:0];
                    n_out_feat  = w_sat;
                    n_out_last  = (r_k + 7'd1 == r_cnt);
                    n_k         = r_k + 7'd1;
                    n_state     = S_C_START;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bin_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_band_low  <= 6'd0;
            r_band_high <= 6'd63;
            r_keep_c0   <= 1'b1;
            r_num_cep   <= 6'd12;
            r_fb_only   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bin_cnt   <= n_bin_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_BAND_LOW:  r_band_low  <= i_cfg_data;
                    REG_BAND_HIGH: r_band_high <= i_cfg_data;
                    REG_KEEP_C0:   r_keep_c0   <= i_cfg_data[0];
                    REG_NUM_CEP:   r_num_cep   <= i_cfg_data;
                    REG_FB_ONLY:   r_fb_only   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_f <= n_f;         r_nband <= n_nband;   r_k <= n_k;       r_cnt <= n_cnt;
        r_fb <= n_fb;       r_start <= n_start;   r_row <= n_row;   r_p <= n_p;
        r_bin <= n_bin;     r_stop <= n_stop;     r_waddr <= n_waddr;
        r_wdata <= n_wdata; r_acc <= n_acc;       r_zero <= n_zero;
        r_out_idx <= n_out_idx; r_out_feat <= n_out_feat; r_out_last <= n_out_last;
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (r_state == S_WMOD && r_waddr < WRW'(WEIGHT_DEPTH))
            mem_w[r_waddr[WAW-1:0]] <= r_wdata;
        r_w_q <= mem_w[r_waddr[WAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_kind == KIND_FILTER && w_index < INDEX_W'(MAX_FILTERS)) begin
            mem_first[w_index[FAW-1:0]] <= w_bin_begin;
            mem_stop[w_index[FAW-1:0]]  <= w_bin_end;
            mem_base[w_index[FAW-1:0]]  <= w_base;
        end
        r_first_q <= mem_first[w_fi[FAW-1:0]];
        r_stop_q  <= mem_stop[w_fi[FAW-1:0]];
        r_base_q  <= mem_base[w_fi[FAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_kind == KIND_DCT && w_index < INDEX_W'(DCT_DIM))
            mem_dct[{w_row, w_index[5:0]}] <= w_value;
        r_coef_q <= mem_dct[{r_row, r_f[5:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_kind == KIND_MAGNITUDE && r_bin_cnt < CW'(MAX_BINS))
            mem_spec[r_bin_cnt[SAW-1:0]] <= w_value[31] ? 31'd0 : w_value[30:0];
        r_spec_q <= mem_spec[r_bin[SAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_L_WR)
            mem_log[r_f[5:0]] <= r_zero ? DB_FLOOR_Q8 : w_db;
        r_log_q <= mem_log[w_log_ra];
    end

endmodule

// ----- sv/mfld_checker.sv -----
`include "mel_filterbank_log_dct_defines.svh"

module mfld_checker
    import mfld_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [1:0] i_s_axis_tuser,
    input logic       i_s_axis_tlast,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic       o_m_axis_tlast
);

    // A result waiting on the output is never withdrawn.
    `MFLD_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "output transaction dropped while stalled")

    // A frame end starts the computation pass, so the input closes at once.
    `MFLD_ASSERT_NEXT(a_frame_busy, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == KIND_MAGNITUDE && i_s_axis_tlast, !o_s_axis_tready, "input open right after frame end")

    // While a frame's results are still coming, no new item may enter.
    `MFLD_ASSERT_NOW(a_no_input_mid_frame, o_m_axis_tvalid && !o_m_axis_tlast, !o_s_axis_tready, "input open before the last feature")

    // A new result only appears out of a computation pass.
    `MFLD_ASSERT_NOW(a_out_from_busy, $rose(o_m_axis_tvalid), $past(!o_s_axis_tready), "output appeared while idle")

endmodule

bind mel_filterbank_log_dct mfld_checker u_mfld_checker (.*);
